@@ rtl/flow_pair_counter_table_macros.svh @@
// Assertion macros for the flow table block.
`ifndef FLOW_PAIR_COUNTER_TABLE_MACROS_SVH
`define FLOW_PAIR_COUNTER_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
`define FPCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");
`define FPCT_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define FPCT_ASSERT_IMP(lbl, ante, cons)
`define FPCT_ASSERT_NEVER(lbl, expr)
`endif
`endif

@@ rtl/fpct_pkg.sv @@
package fpct_pkg;

  localparam int unsigned BUCKETS    = 1024;
  localparam int unsigned WAYS       = 4;
  localparam int unsigned SLOTS      = BUCKETS * WAYS;
  localparam int unsigned BKT_W      = $clog2(BUCKETS);
  localparam int unsigned WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SLOT_W     = 12;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned MIX_W      = 27;
  localparam int unsigned PROD_W     = 32 + MIX_W;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned DIV_STEPS  = KEY_W / 2;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned CLR_W      = $clog2(BUCKETS);

  localparam logic [MIX_W-1:0] MIX_MUL = 27'h45d9f3b;

  localparam logic [2:0] STAT_NEW     = 3'd0;
  localparam logic [2:0] STAT_UPDATED = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_EMPTY   = 3'd3;
  localparam logic [2:0] STAT_VALID   = 3'd4;

  localparam logic OP_ACCOUNT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [31:0]      packets;
    logic [63:0]      udp;
    logic [63:0]      tcp;
    logic [63:0]      icmp;
  } entry_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [BKT_W-1:0] bucket;
    logic [1:0]       way;
    entry_t           ent;
  } result_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_DIV_GO,
    ST_DIV,
    ST_ROW,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_WRITE,
    ST_RD_SLOT,
    ST_RD_WAIT,
    ST_EMIT
  } state_e;

endpackage

@@ rtl/fpct_mul.sv @@
// Shared 32 x 27 multiplier by the mix constant, registered product.
module fpct_mul (
  input  logic                         clk_i,
  input  logic [31:0]                  a_i,
  output logic [fpct_pkg::PROD_W-1:0] p_o
);

  logic [fpct_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= fpct_pkg::PROD_W'(a_i) * fpct_pkg::PROD_W'(fpct_pkg::MIX_MUL);
  end

  assign p_o = p_q;

endmodule

@@ rtl/fpct_div.sv @@
// Radix-4 restoring remainder unit, two dividend bits per cycle.
module fpct_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [fpct_pkg::KEY_W-1:0]  dividend_i,
  input  logic [fpct_pkg::CNT_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [fpct_pkg::CNT_W-1:0]  rem_o
);

  localparam int unsigned T_W = fpct_pkg::CNT_W + 2;

  logic                           busy_q, done_q;
  logic [fpct_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [fpct_pkg::KEY_W-1:0]     d_q;
  logic [fpct_pkg::CNT_W-1:0]     r_q, r_d, n_q;
  logic [T_W-1:0]                 t, n1, n2, n3;

  always_comb begin
    t  = {r_q, d_q[fpct_pkg::KEY_W-1 -: 2]};
    n1 = T_W'(n_q);
    n2 = n1 << 1;
    n3 = n1 + n2;
    priority if (t >= n3) begin
      r_d = fpct_pkg::CNT_W'(t - n3);
    end else if (t >= n2) begin
      r_d = fpct_pkg::CNT_W'(t - n2);
    end else if (t >= n1) begin
      r_d = fpct_pkg::CNT_W'(t - n1);
    end else begin
      r_d = fpct_pkg::CNT_W'(t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == fpct_pkg::DIV_CNT_W'(fpct_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q <= dividend_i;
      r_q <= '0;
      n_q <= divisor_i;
    end else if (busy_q) begin
      d_q <= d_q << 2;
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

@@ rtl/fpct_store.sv @@
// Per-bucket valid rows and the entry memory, both with registered reads.
module fpct_store (
  input  logic                          clk_i,
  input  logic                          vrow_re_i,
  input  logic [fpct_pkg::BKT_W-1:0]   vrow_raddr_i,
  output logic [fpct_pkg::WAYS-1:0]    vrow_rdata_o,
  input  logic                          vrow_we_i,
  input  logic [fpct_pkg::BKT_W-1:0]   vrow_waddr_i,
  input  logic [fpct_pkg::WAYS-1:0]    vrow_wdata_i,
  input  logic                          ent_re_i,
  input  logic [fpct_pkg::SLOT_W-1:0]  ent_raddr_i,
  output fpct_pkg::entry_t              ent_rdata_o,
  input  logic                          ent_we_i,
  input  logic [fpct_pkg::SLOT_W-1:0]  ent_waddr_i,
  input  fpct_pkg::entry_t              ent_wdata_i
);

  logic [fpct_pkg::WAYS-1:0] vrow_mem [fpct_pkg::BUCKETS];
  fpct_pkg::entry_t          ent_mem  [fpct_pkg::SLOTS];
  logic [fpct_pkg::WAYS-1:0] vrow_q;
  fpct_pkg::entry_t          ent_q;

  always_ff @(posedge clk_i) begin
    if (vrow_we_i) begin
      vrow_mem[vrow_waddr_i] <= vrow_wdata_i;
    end
    if (vrow_re_i) begin
      vrow_q <= vrow_mem[vrow_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we_i) begin
      ent_mem[ent_waddr_i] <= ent_wdata_i;
    end
    if (ent_re_i) begin
      ent_q <= ent_mem[ent_raddr_i];
    end
  end

  assign vrow_rdata_o = vrow_q;
  assign ent_rdata_o  = ent_q;

endmodule

@@ rtl/flow_pair_counter_table.sv @@
// Account op: the key mix runs two rounds on the shared 32x27 multiplier (low half, high
// half, sum), the bucket remainder from the radix-4 unit (start, 32 steps, done), and
// the way scan reads and compares one way at a time until a match or the last way.
// Read op: slot read, wait, emit. One item at a time: input stalls while one is in work,
// so a new transfer is taken only after the emit state hands the result out and goes idle.
// Reset: async active low; then a pass clears all 1024 valid rows, input stalled.
`include "flow_pair_counter_table_macros.svh"
module flow_pair_counter_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] source_ip_i,
  input  logic [31:0] dest_ip_i,
  input  logic [15:0] udp_len_i,
  input  logic [15:0] tcp_len_i,
  input  logic [15:0] icmp_len_i,
  input  logic [11:0] slot_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [9:0]  bucket_o,
  output logic [1:0]  way_o,
  output logic [31:0] flow_source_o,
  output logic [31:0] flow_dest_o,
  output logic [31:0] packet_total_o,
  output logic [63:0] udp_total_o,
  output logic [63:0] tcp_total_o,
  output logic [63:0] icmp_total_o
);

  fpct_pkg::state_e state_q, state_d;

  logic [fpct_pkg::CNT_W-1:0]  bcount_q, n_eff;
  logic [fpct_pkg::CLR_W-1:0]  clr_q, clr_d;
  logic [fpct_pkg::KEY_W-1:0]  k_q, k_d, key_q, key_d, fold;
  logic [fpct_pkg::PROD_W-1:0] acc_q, acc_d, prod;
  logic                        rnd_q, rnd_d;
  logic [15:0]                 ul_q, tl_q, il_q, ul_d, tl_d, il_d;
  logic [fpct_pkg::SLOT_W-1:0] slot_q, slot_d;
  logic [fpct_pkg::BKT_W-1:0]  b_q, b_d;
  logic [fpct_pkg::WAY_W-1:0]  w_q, w_d, fw_q, fw_d;
  logic                        free_q, free_d;
  fpct_pkg::result_t           res_q, res_d, out_q, out_d;
  logic                        out_valid_q, out_valid_d;
  logic [31:0]                 mul_a;
  logic                        div_start, div_done;
  logic [fpct_pkg::CNT_W-1:0]  div_rem;
  logic                        vrow_re, vrow_we, ent_re, ent_we;
  logic [fpct_pkg::BKT_W-1:0]  vrow_raddr, vrow_waddr;
  logic [fpct_pkg::WAYS-1:0]   vrow_rdata, vrow_wdata;
  logic [fpct_pkg::SLOT_W-1:0] ent_raddr, ent_waddr, scan_addr;
  fpct_pkg::entry_t            ent_rdata, ent_wdata;
  logic                        in_xfer, out_free;

  fpct_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .p_o   (prod)
  );

  fpct_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (fold),
    .divisor_i  (bcount_q == '0 ? fpct_pkg::CNT_W'(1) : n_eff),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  fpct_store u_store (
    .clk_i        (clk_i),
    .vrow_re_i    (vrow_re),
    .vrow_raddr_i (vrow_raddr),
    .vrow_rdata_o (vrow_rdata),
    .vrow_we_i    (vrow_we),
    .vrow_waddr_i (vrow_waddr),
    .vrow_wdata_i (vrow_wdata),
    .ent_re_i     (ent_re),
    .ent_raddr_i  (ent_raddr),
    .ent_rdata_o  (ent_rdata),
    .ent_we_i     (ent_we),
    .ent_waddr_i  (ent_waddr),
    .ent_wdata_i  (ent_wdata)
  );

  // bucket_count of 0 acts as 1 (handled at the divider), above the table acts as full size
  assign n_eff = (bcount_q > fpct_pkg::CNT_W'(fpct_pkg::BUCKETS)) ?
                 fpct_pkg::CNT_W'(fpct_pkg::BUCKETS) : bcount_q;
  assign fold      = k_q ^ (k_q >> 32);
  assign in_stall_o = (state_q != fpct_pkg::ST_IDLE);
  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_addr = fpct_pkg::SLOT_W'(b_q * fpct_pkg::WAYS + w_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    k_d         = k_q;
    key_d       = key_q;
    acc_d       = acc_q;
    rnd_d       = rnd_q;
    ul_d        = ul_q;
    tl_d        = tl_q;
    il_d        = il_q;
    slot_d      = slot_q;
    b_d         = b_q;
    w_d         = w_q;
    fw_d        = fw_q;
    free_d      = free_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_a       = fold[31:0];
    div_start   = 1'b0;
    vrow_re     = 1'b0;
    vrow_raddr  = b_q;
    vrow_we     = 1'b0;
    vrow_waddr  = b_q;
    vrow_wdata  = '0;
    ent_re      = 1'b0;
    ent_raddr   = scan_addr;
    ent_we      = 1'b0;
    ent_waddr   = scan_addr;
    ent_wdata   = ent_rdata;
    unique case (state_q)
      fpct_pkg::ST_CLEAR: begin
        vrow_we    = 1'b1;
        vrow_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == fpct_pkg::CLR_W'(fpct_pkg::BUCKETS - 1)) begin
          state_d = fpct_pkg::ST_IDLE;
        end
      end
      fpct_pkg::ST_IDLE: begin
        if (in_xfer) begin
          k_d    = {source_ip_i, dest_ip_i};
          key_d  = {source_ip_i, dest_ip_i};
          ul_d   = udp_len_i;
          tl_d   = tcp_len_i;
          il_d   = icmp_len_i;
          slot_d = slot_index_i;
          rnd_d  = 1'b0;
          state_d = (op_i == fpct_pkg::OP_READ) ? fpct_pkg::ST_RD_SLOT
                                                : fpct_pkg::ST_MUL_LO;
        end
      end
      fpct_pkg::ST_MUL_LO: begin
        mul_a   = fold[31:0];
        state_d = fpct_pkg::ST_MUL_HI;
      end
      fpct_pkg::ST_MUL_HI: begin
        mul_a   = fold[63:32];
        acc_d   = prod;
        state_d = fpct_pkg::ST_MUL_SUM;
      end
      fpct_pkg::ST_MUL_SUM: begin
        // (hi*M << 32) + lo*M, modulo 2^64
        k_d   = fpct_pkg::KEY_W'(acc_q) + {prod[31:0], 32'd0};
        rnd_d = 1'b1;
        state_d = rnd_q ? fpct_pkg::ST_DIV_GO : fpct_pkg::ST_MUL_LO;
      end
      fpct_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = fpct_pkg::ST_DIV;
      end
      fpct_pkg::ST_DIV: begin
        if (div_done) begin
          b_d     = div_rem[fpct_pkg::BKT_W-1:0];
          state_d = fpct_pkg::ST_ROW;
        end
      end
      fpct_pkg::ST_ROW: begin
        vrow_re = 1'b1;
        w_d     = '0;
        free_d  = 1'b0;
        fw_d    = '0;
        state_d = fpct_pkg::ST_SCAN_RD;
      end
      fpct_pkg::ST_SCAN_RD: begin
        ent_re  = 1'b1;
        state_d = fpct_pkg::ST_SCAN_CMP;
      end
      fpct_pkg::ST_SCAN_CMP: begin
        res_d.bucket = b_q;
        if (vrow_rdata[w_q] && ent_rdata.key == key_q) begin
          res_d.status = fpct_pkg::STAT_UPDATED;
          res_d.way    = 2'(w_q);
          state_d      = fpct_pkg::ST_WRITE;
        end else begin
          if (!vrow_rdata[w_q] && !free_q) begin
            free_d = 1'b1;
            fw_d   = w_q;
          end
          if (w_q == fpct_pkg::WAY_W'(fpct_pkg::WAYS - 1)) begin
            res_d.status = (free_d) ? fpct_pkg::STAT_NEW : fpct_pkg::STAT_FULL;
            res_d.way    = free_d ? 2'(fw_d) : 2'd0;
            state_d      = fpct_pkg::ST_WRITE;
          end else begin
            w_d     = w_q + 1'b1;
            state_d = fpct_pkg::ST_SCAN_RD;
          end
        end
      end
      fpct_pkg::ST_WRITE: begin
        priority case (res_q.status)
          fpct_pkg::STAT_UPDATED: begin
            ent_wdata.key     = key_q;
            ent_wdata.packets = ent_rdata.packets + 32'd1;
            ent_wdata.udp     = ent_rdata.udp + 64'(ul_q);
            ent_wdata.tcp     = ent_rdata.tcp + 64'(tl_q);
            ent_wdata.icmp    = ent_rdata.icmp + 64'(il_q);
            ent_we    = 1'b1;
          end
          fpct_pkg::STAT_NEW: begin
            ent_wdata.key     = key_q;
            ent_wdata.packets = 32'd1;
            ent_wdata.udp     = 64'(ul_q);
            ent_wdata.tcp     = 64'(tl_q);
            ent_wdata.icmp    = 64'(il_q);
            ent_we     = 1'b1;
            ent_waddr  = fpct_pkg::SLOT_W'(b_q * fpct_pkg::WAYS + fw_q);
            vrow_we    = 1'b1;
            vrow_wdata = vrow_rdata | (fpct_pkg::WAYS'(1) << fw_q);
          end
          default: begin
            ent_wdata = '0;
            ent_wdata.key = key_q;
          end
        endcase
        res_d.ent = ent_wdata;
        state_d   = fpct_pkg::ST_EMIT;
      end
      fpct_pkg::ST_RD_SLOT: begin
        vrow_re    = 1'b1;
        vrow_raddr = fpct_pkg::BKT_W'(slot_q / fpct_pkg::WAYS);
        ent_re     = 1'b1;
        ent_raddr  = slot_q;
        state_d    = fpct_pkg::ST_RD_WAIT;
      end
      fpct_pkg::ST_RD_WAIT: begin
        res_d.bucket = fpct_pkg::BKT_W'(slot_q / fpct_pkg::WAYS);
        res_d.way    = 2'(slot_q % fpct_pkg::WAYS);
        if ((fpct_pkg::SLOT_W + 1)'(slot_q) < (fpct_pkg::SLOT_W + 1)'(fpct_pkg::SLOTS) &&
            vrow_rdata[fpct_pkg::WAY_W'(slot_q % fpct_pkg::WAYS)]) begin
          res_d.status = fpct_pkg::STAT_VALID;
          res_d.ent    = ent_rdata;
        end else begin
          res_d.status = fpct_pkg::STAT_EMPTY;
          res_d.ent    = '0;
        end
        state_d = fpct_pkg::ST_EMIT;
      end
      fpct_pkg::ST_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = fpct_pkg::ST_IDLE;
        end
      end
      default: state_d = fpct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpct_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      bcount_q    <= fpct_pkg::CNT_W'(fpct_pkg::BUCKETS);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        bcount_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    key_q  <= key_d;
    acc_q  <= acc_d;
    rnd_q  <= rnd_d;
    ul_q   <= ul_d;
    tl_q   <= tl_d;
    il_q   <= il_d;
    slot_q <= slot_d;
    b_q    <= b_d;
    w_q    <= w_d;
    fw_q   <= fw_d;
    free_q <= free_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign bucket_o       = out_q.bucket;
  assign way_o          = out_q.way;
  assign flow_source_o  = out_q.ent.key[63:32];
  assign flow_dest_o    = out_q.ent.key[31:0];
  assign packet_total_o = out_q.ent.packets;
  assign udp_total_o    = out_q.ent.udp;
  assign tcp_total_o    = out_q.ent.tcp;
  assign icmp_total_o   = out_q.ent.icmp;

  `FPCT_ASSERT_IMP(a_clear_stalls, state_q == fpct_pkg::ST_CLEAR, in_stall_o)
  `FPCT_ASSERT_IMP(a_new_one_pkt, out_valid_o && status_o == fpct_pkg::STAT_NEW, packet_total_o == 32'd1)
  `FPCT_ASSERT_IMP(a_full_zero, out_valid_o && status_o == fpct_pkg::STAT_FULL, packet_total_o == 32'd0 && way_o == 2'd0)
  `FPCT_ASSERT_NEVER(a_status_range, out_valid_o && status_o > fpct_pkg::STAT_VALID)

endmodule
